// File: src/qoi_pixel_stream_decoder_assert.svh
// Assertion macros for the QOI decoder checker.
`ifndef QOI_PIXEL_STREAM_DECODER_ASSERT_SVH
`define QOI_PIXEL_STREAM_DECODER_ASSERT_SVH

// Checked outside reset.
`define QOI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked during reset as well.
`define QOI_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/qoi_pkg.sv
`timescale 1ns / 1ps

package qoi_pkg;

  localparam int TBL_DEPTH  = 64;
  localparam int TBL_AW     = $clog2(TBL_DEPTH);
  localparam int COLOR_W    = 32;
  localparam int PIX_DATA_W = 24;

  typedef enum logic [1:0] {
    CH_NONE = 2'd0,
    CH_RGB  = 2'd1,
    CH_RGBA = 2'd2,
    CH_LUMA = 2'd3
  } chunk_t;

  localparam logic [7:0] TAG_RGB  = 8'hFE;
  localparam logic [7:0] TAG_RGBA = 8'hFF;

  localparam logic [1:0] OP_INDEX = 2'd0;
  localparam logic [1:0] OP_DIFF  = 2'd1;
  localparam logic [1:0] OP_LUMA  = 2'd2;
  localparam logic [1:0] OP_RUN   = 2'd3;

  // Table slot: (r*3 + g*5 + b*7 + a*11) mod 64.
  function automatic logic [TBL_AW-1:0] color_hash(input logic [COLOR_W-1:0] c);
    logic [TBL_AW-1:0] r, g, b, a;
    r = c[24 +: TBL_AW];
    g = c[16 +: TBL_AW];
    b = c[8  +: TBL_AW];
    a = c[0  +: TBL_AW];
    return r * TBL_AW'(3) + g * TBL_AW'(5) + b * TBL_AW'(7) + a * TBL_AW'(11);
  endfunction

endpackage

// File: src/qoi_pixel_stream_decoder.sv
`timescale 1ns / 1ps

// QOI chunk decoder: takes the chunk stream after the header, one byte per transfer, with
// tlast on the final data byte of the image, and returns one RGB pixel per output transfer
// (tlast on the last pixel of each chunk). After a byte that does not finish a chunk the
// decoder stays ready for the next byte. A finished DIFF, LUMA, RGB, RGBA or RUN chunk
// passes through S_WRITE, which writes its color to the 64-entry color table, then S_EMIT;
// an INDEX chunk first passes through S_LOAD for the registered read of the table. The
// input is held until the last pixel of the chunk is placed on the output. The table
// needs no clearing pass: per-entry valid bits clear at reset and after the final byte.
module qoi_pixel_stream_decoder
  import qoi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] stream_byte
  input  logic                  s_axis_tlast,   // last_byte
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [PIX_DATA_W-1:0] m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  output logic                  m_axis_tlast    // run_end
);

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_WRITE, S_EMIT} state_t;

  state_t               state;
  logic [7:0]           pix_r, pix_g, pix_b, pix_a;
  chunk_t               pending;
  logic [2:0]           bytes_left;
  logic [5:0]           luma_dg;
  logic [5:0]           run_count;
  logic                 last_hold;
  logic [TBL_DEPTH-1:0] valid;
  logic                 idx_valid;

  logic                 ram_we;
  logic [TBL_AW-1:0]    ram_waddr;
  logic [COLOR_W-1:0]   ram_wdata;
  logic [COLOR_W-1:0]   ram_rdata;

  logic                 in_xfer;
  logic                 out_free;
  logic [1:0]           pay_pos;
  logic [7:0]           luma_bias;

  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign ram_wdata = {pix_r, pix_g, pix_b, pix_a};
  assign ram_waddr = color_hash(ram_wdata);
  assign ram_we    = (state == S_WRITE);

  assign pay_pos   = (pending == CH_RGB) ? 2'(3'd3 - bytes_left) : 2'(3'd4 - bytes_left);
  assign luma_bias = {2'b00, luma_dg};

  qoi_ram #(.DEPTH(TBL_DEPTH), .WIDTH(COLOR_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (s_axis_tdata[TBL_AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pix_r         <= '0;
      pix_g         <= '0;
      pix_b         <= '0;
      pix_a         <= 8'hFF;
      pending       <= CH_NONE;
      bytes_left    <= '0;
      luma_dg       <= '0;
      run_count     <= '0;
      last_hold     <= 1'b0;
      valid         <= '0;
      idx_valid     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready && state != S_EMIT) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            last_hold <= s_axis_tlast;
            if (pending != CH_NONE && bytes_left != '0) begin
              if (pending == CH_LUMA) begin
                pix_r <= pix_r + {4'h0, s_axis_tdata[7:4]} + luma_bias + 8'd216;
                pix_g <= pix_g + luma_bias + 8'd224;
                pix_b <= pix_b + {4'h0, s_axis_tdata[3:0]} + luma_bias + 8'd216;
                bytes_left <= '0;
                pending    <= CH_NONE;
                state      <= S_WRITE;
              end else if (bytes_left != 3'd1 && s_axis_tlast) begin
                pix_r      <= '0;
                pix_g      <= '0;
                pix_b      <= '0;
                pix_a      <= 8'hFF;
                pending    <= CH_NONE;
                bytes_left <= '0;
                luma_dg    <= '0;
                valid      <= '0;
              end else begin
                case (pay_pos)
                  2'd0:    pix_r <= s_axis_tdata;
                  2'd1:    pix_g <= s_axis_tdata;
                  2'd2:    pix_b <= s_axis_tdata;
                  default: pix_a <= s_axis_tdata;
                endcase
                bytes_left <= bytes_left - 3'd1;
                if (bytes_left == 3'd1) begin
                  pending <= CH_NONE;
                  state   <= S_WRITE;
                end
              end
            end else if (s_axis_tdata == TAG_RGB || s_axis_tdata == TAG_RGBA) begin
              if (s_axis_tlast) begin
                pix_r      <= '0;
                pix_g      <= '0;
                pix_b      <= '0;
                pix_a      <= 8'hFF;
                pending    <= CH_NONE;
                bytes_left <= '0;
                luma_dg    <= '0;
                valid      <= '0;
              end else begin
                pending    <= (s_axis_tdata == TAG_RGB) ? CH_RGB : CH_RGBA;
                bytes_left <= (s_axis_tdata == TAG_RGB) ? 3'd3 : 3'd4;
              end
            end else begin
              case (s_axis_tdata[7:6])
                OP_INDEX: begin
                  idx_valid <= valid[s_axis_tdata[TBL_AW-1:0]];
                  state     <= S_LOAD;
                end
                OP_DIFF: begin
                  pix_r <= pix_r + {6'h00, s_axis_tdata[5:4]} + 8'd254;
                  pix_g <= pix_g + {6'h00, s_axis_tdata[3:2]} + 8'd254;
                  pix_b <= pix_b + {6'h00, s_axis_tdata[1:0]} + 8'd254;
                  state <= S_WRITE;
                end
                OP_LUMA: begin
                  if (s_axis_tlast) begin
                    pix_r      <= '0;
                    pix_g      <= '0;
                    pix_b      <= '0;
                    pix_a      <= 8'hFF;
                    pending    <= CH_NONE;
                    bytes_left <= '0;
                    luma_dg    <= '0;
                    valid      <= '0;
                  end else begin
                    pending    <= CH_LUMA;
                    bytes_left <= 3'd1;
                    luma_dg    <= s_axis_tdata[5:0];
                  end
                end
                default: begin
                  run_count <= s_axis_tdata[5:0];
                  state     <= S_WRITE;
                end
              endcase
            end
          end
        end
        S_LOAD: begin
          if (idx_valid) begin
            pix_r <= ram_rdata[31:24];
            pix_g <= ram_rdata[23:16];
            pix_b <= ram_rdata[15:8];
            pix_a <= ram_rdata[7:0];
          end else begin
            pix_r <= '0;
            pix_g <= '0;
            pix_b <= '0;
            pix_a <= '0;
          end
          state <= S_WRITE;
        end
        S_WRITE: begin
          valid[ram_waddr] <= 1'b1;
          state            <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {pix_b, pix_g, pix_r};
            m_axis_tlast  <= (run_count == '0);
            if (run_count == '0) begin
              state <= S_IDLE;
              if (last_hold) begin
                pix_r      <= '0;
                pix_g      <= '0;
                pix_b      <= '0;
                pix_a      <= 8'hFF;
                pending    <= CH_NONE;
                bytes_left <= '0;
                luma_dg    <= '0;
                valid      <= '0;
              end
            end else begin
              run_count <= run_count - 6'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/qoi_ram.sv
`timescale 1ns / 1ps

module qoi_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/qoi_checker.sv
`timescale 1ns / 1ps

`include "qoi_pixel_stream_decoder_assert.svh"

module qoi_checker
  import qoi_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [7:0]            s_axis_tdata,
  input logic                  s_axis_tlast,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [PIX_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast
);

  logic out_xfer;

  assign out_xfer = m_axis_tvalid && m_axis_tready;

  `QOI_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output dropped")
  `QOI_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "data moved")
  `QOI_ASSERT_RST(a_rst_quiet, rst |=> !m_axis_tvalid, "output valid after reset")
  `QOI_ASSERT(a_run_blocks_in, m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready, "input mid-run")
  `QOI_ASSERT(a_run_continues, out_xfer && !m_axis_tlast |=> m_axis_tvalid, "run gap")

endmodule

bind qoi_pixel_stream_decoder qoi_checker u_qoi_checker (.*);
